### src/tked_pkg.sv
// ----------------------------------------------------------------------------
// tked_pkg
// Shared action codes and byte constants for the terminal key escape decoder.
// ----------------------------------------------------------------------------
package tked_pkg;

	typedef logic [3:0] action_t;

	localparam action_t ACT_NONE       = 4'd0;
	localparam action_t ACT_LINE_START = 4'd1;
	localparam action_t ACT_DELETE     = 4'd2;
	localparam action_t ACT_LINE_END   = 4'd3;
	localparam action_t ACT_COMPLETE   = 4'd4;
	localparam action_t ACT_SUBMIT     = 4'd5;
	localparam action_t ACT_BACKSPACE  = 4'd6;
	localparam action_t ACT_INSERT     = 4'd7;
	localparam action_t ACT_UP         = 4'd8;
	localparam action_t ACT_DOWN       = 4'd9;
	localparam action_t ACT_BACK       = 4'd10;
	localparam action_t ACT_FORWARD    = 4'd11;

	localparam logic [7:0] KEY_CTRL_A = 8'd1;
	localparam logic [7:0] KEY_CTRL_D = 8'd4;
	localparam logic [7:0] KEY_CTRL_E = 8'd5;
	localparam logic [7:0] KEY_BS     = 8'd8;
	localparam logic [7:0] KEY_TAB    = 8'd9;
	localparam logic [7:0] KEY_LF     = 8'd10;
	localparam logic [7:0] KEY_CR     = 8'd13;
	localparam logic [7:0] KEY_ESC    = 8'd27;
	localparam logic [7:0] KEY_SPACE  = 8'd32;
	localparam logic [7:0] KEY_DEL    = 8'd127;
	localparam logic [7:0] KEY_CSI    = 8'd155;
	localparam logic [7:0] KEY_LBRACK = 8'h5B;
	localparam logic [7:0] KEY_TILDE  = 8'h7E;
	localparam logic [7:0] KEY_ZERO   = 8'h30;
	localparam logic [7:0] KEY_NINE   = 8'h39;
	localparam logic [7:0] KEY_A      = 8'h41;
	localparam logic [7:0] KEY_B      = 8'h42;
	localparam logic [7:0] KEY_C      = 8'h43;
	localparam logic [7:0] KEY_D      = 8'h44;
	localparam logic [7:0] KEY_E      = 8'h45;
	localparam logic [7:0] KEY_F      = 8'h46;

	localparam int SEQ_W = 16;
	localparam logic [SEQ_W-1:0] SEQ_MAX = '1;

endpackage

### src/terminal_key_escape_decoder.sv
// ----------------------------------------------------------------------------
// terminal_key_escape_decoder
// Decodes terminal key bytes and escape sequences into line-editing actions.
// ----------------------------------------------------------------------------
// One key byte in, one action out. Each item goes through an input register
// and a result register with a single decode step between them. out_valid
// rises as the item enters the result register; one item is taken per cycle
// while out_ready is high. The parser state (mode and CSI parameter) updates
// in that same cycle. The input stage keeps accepting while a result waits,
// and only stalls when both registers are full and out_ready is low.
module terminal_key_escape_decoder (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [7:0]           key_byte,
	output logic                 out_valid,
	input  logic                 out_ready,
	output tked_pkg::action_t    action,
	output logic [7:0]           char_out
);

	typedef enum logic [1:0] {
		MODE_NORMAL = 2'd0,
		MODE_ESC    = 2'd1,
		MODE_CSI    = 2'd2
	} mode_t;

	mode_t                       mode_q, mode_d;
	logic [tked_pkg::SEQ_W-1:0]  seq_q, seq_d;

	logic                        valid_s1;
	logic [7:0]                  byte_s1;
	logic                        valid_s2;
	tked_pkg::action_t           action_s2, action_d;
	logic [7:0]                  char_s2, char_d;

	logic                        advance;
	logic [tked_pkg::SEQ_W+3:0]  seq_mul;
	logic [3:0]                  digit;

	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	assign digit   = 4'(byte_s1 - tked_pkg::KEY_ZERO);
	// seq*10 + digit, 20 bits always holds it
	assign seq_mul = ({4'd0, seq_q} << 3) + ({4'd0, seq_q} << 1) + {16'd0, digit};

	always_comb begin
		mode_d   = mode_q;
		seq_d    = seq_q;
		action_d = tked_pkg::ACT_NONE;
		char_d   = 8'd0;
		unique case (mode_q)
			MODE_ESC: begin
				if (byte_s1 == tked_pkg::KEY_LBRACK) begin
					mode_d = MODE_CSI;
					seq_d  = '0;
				end else begin
					mode_d = MODE_NORMAL;
				end
			end
			MODE_CSI: begin
				if (byte_s1 >= tked_pkg::KEY_ZERO && byte_s1 <= tked_pkg::KEY_NINE) begin
					seq_d = (seq_mul > {4'd0, tked_pkg::SEQ_MAX}) ? tked_pkg::SEQ_MAX
					                                             : seq_mul[tked_pkg::SEQ_W-1:0];
				end else begin
					mode_d = MODE_NORMAL;
					unique case (byte_s1)
						tked_pkg::KEY_A, tked_pkg::KEY_F: action_d = tked_pkg::ACT_UP;
						tked_pkg::KEY_B, tked_pkg::KEY_E: action_d = tked_pkg::ACT_DOWN;
						tked_pkg::KEY_D:                  action_d = tked_pkg::ACT_BACK;
						tked_pkg::KEY_C:                  action_d = tked_pkg::ACT_FORWARD;
						tked_pkg::KEY_TILDE: begin
							priority if (seq_q == 16'd1) action_d = tked_pkg::ACT_LINE_START;
							else if (seq_q == 16'd3)     action_d = tked_pkg::ACT_DELETE;
							else if (seq_q == 16'd4)     action_d = tked_pkg::ACT_LINE_END;
							else                         action_d = tked_pkg::ACT_NONE;
						end
						default: action_d = tked_pkg::ACT_NONE;
					endcase
				end
			end
			default: begin
				// normal, and the unused code behaves the same
				mode_d = MODE_NORMAL;
				unique case (byte_s1)
					tked_pkg::KEY_CTRL_A:             action_d = tked_pkg::ACT_LINE_START;
					tked_pkg::KEY_CTRL_D:             action_d = tked_pkg::ACT_DELETE;
					tked_pkg::KEY_CTRL_E:             action_d = tked_pkg::ACT_LINE_END;
					tked_pkg::KEY_TAB:                action_d = tked_pkg::ACT_COMPLETE;
					tked_pkg::KEY_LF, tked_pkg::KEY_CR: action_d = tked_pkg::ACT_SUBMIT;
					tked_pkg::KEY_BS, tked_pkg::KEY_DEL: action_d = tked_pkg::ACT_BACKSPACE;
					tked_pkg::KEY_ESC:                mode_d   = MODE_ESC;
					// parameter is kept here
					tked_pkg::KEY_CSI:                mode_d   = MODE_CSI;
					default: begin
						if (byte_s1 >= tked_pkg::KEY_SPACE) begin
							action_d = tked_pkg::ACT_INSERT;
							char_d   = byte_s1;
						end
					end
				endcase
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			byte_s1   <= 8'd0;
			valid_s2  <= 1'b0;
			action_s2 <= tked_pkg::ACT_NONE;
			char_s2   <= 8'd0;
			mode_q    <= MODE_NORMAL;
			seq_q     <= '0;
		end else begin
			if (in_valid && in_ready) begin
				valid_s1 <= 1'b1;
				byte_s1  <= key_byte;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2  <= 1'b1;
				action_s2 <= action_d;
				char_s2   <= char_d;
				mode_q    <= mode_d;
				seq_q     <= seq_d;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	assign out_valid = valid_s2;
	assign action    = action_s2;
	assign char_out  = char_s2;

endmodule

### src/tked_checker.sv
// ----------------------------------------------------------------------------
// tked_checker
// Port-level checks for the terminal key escape decoder.
// ----------------------------------------------------------------------------
module tked_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_ready,
	input  logic [7:0]        key_byte,
	input  logic              out_valid,
	input  logic              out_ready,
	input  tked_pkg::action_t action,
	input  logic [7:0]        char_out
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(action) && $stable(char_out))
		else $error("result changed while stalled");

	a_char_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && action != tked_pkg::ACT_INSERT |-> char_out == 8'd0)
		else $error("char_out nonzero for non-insert action");

	a_action_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> action <= tked_pkg::ACT_FORWARD)
		else $error("action code out of range");

	// bytes below space, DEL and CSI never get inserted
	a_insert_printable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && action == tked_pkg::ACT_INSERT |->
			char_out >= tked_pkg::KEY_SPACE && char_out != tked_pkg::KEY_DEL &&
			char_out != tked_pkg::KEY_CSI)
		else $error("inserted byte is a control byte");

endmodule

bind terminal_key_escape_decoder tked_checker u_tked_checker (.*);
